### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the proximity veto.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, off while reset is low.
`define PPV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define PPV_NEVER(lbl, clk, rst_n, cond, msg) \
    `PPV_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/core/ppv_pkg.sv
package ppv_pkg;

    localparam int COORD_W   = 18;
    localparam int THR_W     = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W + 2;
    localparam int FULL_W    = (SQ_W > 2 * THR_W) ? SQ_W : 2 * THR_W;
    localparam int HALF_W    = (FULL_W + 1) / 2;
    localparam int MOP_W     = HALF_W + 1;
    localparam int PROD_W    = 2 * MOP_W;
    localparam int ACC_W     = 4 * HALF_W + 2;
    localparam int NUM_AXES  = 3;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int NUM_REGS  = 4;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_VX  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_VY  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_VZ  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_THR = REG_IDX_W'(3);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(160);

    typedef logic [NUM_AXES-1:0][DIFF_W-1:0] t_diff_vec;

    // One point after classification: differences ready for the math unit.
    typedef struct packed {
        logic      test;
        logic      last;
        t_diff_vec d;
        t_diff_vec wa;
        t_diff_vec wb;
    } t_seg_entry;

endpackage

### rtl/core/ppv_front.sv
module ppv_front
    import ppv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [COORD_W-1:0] i_point_z,
    input  logic               i_track_start,
    input  logic               i_batch_end,
    input  logic [COORD_W-1:0] i_vertex_x,
    input  logic [COORD_W-1:0] i_vertex_y,
    input  logic [COORD_W-1:0] i_vertex_z,
    input  logic               i_q_full,
    output logic               o_push,
    output t_seg_entry         o_entry
);

    logic [NUM_AXES-1:0][COORD_W-1:0] r_prev, n_prev;
    logic                             r_prev_valid, n_prev_valid;
    logic [NUM_AXES-1:0][COORD_W-1:0] cur;
    logic [NUM_AXES-1:0][COORD_W-1:0] vtx;
    logic                             accept;

    assign cur     = {i_point_z, i_point_y, i_point_x};
    assign vtx     = {i_vertex_z, i_vertex_y, i_vertex_x};
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    always_comb begin
        o_entry.test = !i_track_start && r_prev_valid;
        o_entry.last = i_batch_end;
        for (int i = 0; i < NUM_AXES; i++) begin
            o_entry.d[i]  = DIFF_W'($signed(cur[i])) - DIFF_W'($signed(r_prev[i]));
            o_entry.wa[i] = DIFF_W'($signed(vtx[i])) - DIFF_W'($signed(r_prev[i]));
            o_entry.wb[i] = DIFF_W'($signed(vtx[i])) - DIFF_W'($signed(cur[i]));
        end
    end

    always_comb begin
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        if (accept) begin
            n_prev       = cur;
            // a batch end breaks the chain for the next point
            n_prev_valid = !i_batch_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else begin
            r_prev_valid <= n_prev_valid;
        end
        r_prev <= n_prev;
    end

endmodule

### rtl/core/ppv_queue.sv
`include "assert_macros.svh"

module ppv_queue
    import ppv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_seg_entry i_wdata,
    output logic       o_full,
    input  logic       i_pop,
    output t_seg_entry o_rdata,
    output logic       o_empty
);

    t_seg_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]       r_wptr, n_wptr;
    logic [QPTR_W-1:0]       r_rptr, n_rptr;
    logic [QCNT_W-1:0]       r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `PPV_NEVER(a_q_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")
    `PPV_ASSERT(a_q_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

### rtl/core/ppv_back.sv
`include "assert_macros.svh"

module ppv_back
    import ppv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  t_seg_entry       i_entry,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_near_track
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DRN1 = 3'd2;
    localparam logic [2:0] S_CHK1 = 3'd3;
    localparam logic [2:0] S_DRN2 = 3'd4;
    localparam logic [2:0] S_CHK2 = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int TAG_W = 4;
    localparam logic [TAG_W-1:0] TAG_LEN  = 4'd0;
    localparam logic [TAG_W-1:0] TAG_WA   = 4'd1;
    localparam logic [TAG_W-1:0] TAG_WB   = 4'd2;
    localparam logic [TAG_W-1:0] TAG_DOT  = 4'd3;
    localparam logic [TAG_W-1:0] TAG_THR  = 4'd4;
    localparam logic [TAG_W-1:0] TAG_ADD0 = 4'd5;
    localparam logic [TAG_W-1:0] TAG_ADD1 = 4'd6;
    localparam logic [TAG_W-1:0] TAG_ADD2 = 4'd7;
    localparam logic [TAG_W-1:0] TAG_SUB0 = 4'd8;
    localparam logic [TAG_W-1:0] TAG_SUB1 = 4'd9;
    localparam logic [TAG_W-1:0] TAG_SUB2 = 4'd10;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_P1_LAST  = 5'd12;
    localparam logic [STEP_W-1:0] STEP_P2_FIRST = 5'd13;
    localparam logic [STEP_W-1:0] STEP_P2_LAST  = 5'd24;

    function automatic logic signed [MOP_W-1:0] sx(input logic [DIFF_W-1:0] v);
        return MOP_W'($signed(v));
    endfunction

    function automatic logic signed [MOP_W-1:0] zx(input logic [HALF_W-1:0] v);
        return $signed(MOP_W'(v));
    endfunction

    function automatic logic [HALF_W-1:0] hi_of(input logic [FULL_W-1:0] v);
        logic [2*HALF_W-1:0] e;
        e = (2*HALF_W)'(v);
        return e[2*HALF_W-1:HALF_W];
    endfunction

    function automatic logic [HALF_W-1:0] lo_of(input logic [FULL_W-1:0] v);
        return v[HALF_W-1:0];
    endfunction

    logic [2:0]                r_state, n_state;
    logic [STEP_W-1:0]         r_step, n_step;
    t_seg_entry                r_ent, n_ent;
    logic                      r_hit, n_hit;
    logic                      r_near_seen, n_near_seen;
    logic [FULL_W-1:0]         r_len2, n_len2;
    logic [FULL_W-1:0]         r_wa2, n_wa2;
    logic [FULL_W-1:0]         r_wb2, n_wb2;
    logic [FULL_W-1:0]         r_thr2, n_thr2;
    logic signed [FULL_W:0]    r_dot, n_dot;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic [TAG_W-1:0]          r_ptag, n_ptag;
    logic                      r_pvalid, n_pvalid;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_near, n_out_near;

    logic signed [MOP_W-1:0]   op_a, op_b;
    logic [TAG_W-1:0]          op_tag;
    logic [FULL_W-1:0]         pw_full;
    logic signed [FULL_W:0]    pw_dot;
    logic signed [ACC_W-1:0]   pw_acc;
    logic [FULL_W-1:0]         dot_u;
    logic                      near_now;

    assign o_valid      = r_out_valid;
    assign o_near_track = r_out_near;
    assign dot_u        = r_dot[FULL_W-1:0];

    // operand schedule of the shared multiplier
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_tag = TAG_LEN;
        unique case (r_step)
            5'd0:  begin op_a = sx(r_ent.d[0]);  op_b = sx(r_ent.d[0]);  op_tag = TAG_LEN; end
            5'd1:  begin op_a = sx(r_ent.d[1]);  op_b = sx(r_ent.d[1]);  op_tag = TAG_LEN; end
            5'd2:  begin op_a = sx(r_ent.d[2]);  op_b = sx(r_ent.d[2]);  op_tag = TAG_LEN; end
            5'd3:  begin op_a = sx(r_ent.wa[0]); op_b = sx(r_ent.wa[0]); op_tag = TAG_WA;  end
            5'd4:  begin op_a = sx(r_ent.wa[1]); op_b = sx(r_ent.wa[1]); op_tag = TAG_WA;  end
            5'd5:  begin op_a = sx(r_ent.wa[2]); op_b = sx(r_ent.wa[2]); op_tag = TAG_WA;  end
            5'd6:  begin op_a = sx(r_ent.wb[0]); op_b = sx(r_ent.wb[0]); op_tag = TAG_WB;  end
            5'd7:  begin op_a = sx(r_ent.wb[1]); op_b = sx(r_ent.wb[1]); op_tag = TAG_WB;  end
            5'd8:  begin op_a = sx(r_ent.wb[2]); op_b = sx(r_ent.wb[2]); op_tag = TAG_WB;  end
            5'd9:  begin op_a = sx(r_ent.d[0]);  op_b = sx(r_ent.wa[0]); op_tag = TAG_DOT; end
            5'd10: begin op_a = sx(r_ent.d[1]);  op_b = sx(r_ent.wa[1]); op_tag = TAG_DOT; end
            5'd11: begin op_a = sx(r_ent.d[2]);  op_b = sx(r_ent.wa[2]); op_tag = TAG_DOT; end
            5'd12: begin
                op_a   = $signed(MOP_W'(i_thr));
                op_b   = $signed(MOP_W'(i_thr));
                op_tag = TAG_THR;
            end
            // thr2 * len2, added
            5'd13: begin op_a = zx(hi_of(r_thr2)); op_b = zx(hi_of(r_len2)); op_tag = TAG_ADD2; end
            5'd14: begin op_a = zx(hi_of(r_thr2)); op_b = zx(lo_of(r_len2)); op_tag = TAG_ADD1; end
            5'd15: begin op_a = zx(lo_of(r_thr2)); op_b = zx(hi_of(r_len2)); op_tag = TAG_ADD1; end
            5'd16: begin op_a = zx(lo_of(r_thr2)); op_b = zx(lo_of(r_len2)); op_tag = TAG_ADD0; end
            // dot * dot, added
            5'd17: begin op_a = zx(hi_of(dot_u));  op_b = zx(hi_of(dot_u));  op_tag = TAG_ADD2; end
            5'd18: begin op_a = zx(hi_of(dot_u));  op_b = zx(lo_of(dot_u));  op_tag = TAG_ADD1; end
            5'd19: begin op_a = zx(lo_of(dot_u));  op_b = zx(hi_of(dot_u));  op_tag = TAG_ADD1; end
            5'd20: begin op_a = zx(lo_of(dot_u));  op_b = zx(lo_of(dot_u));  op_tag = TAG_ADD0; end
            // wa2 * len2, subtracted
            5'd21: begin op_a = zx(hi_of(r_wa2));  op_b = zx(hi_of(r_len2)); op_tag = TAG_SUB2; end
            5'd22: begin op_a = zx(hi_of(r_wa2));  op_b = zx(lo_of(r_len2)); op_tag = TAG_SUB1; end
            5'd23: begin op_a = zx(lo_of(r_wa2));  op_b = zx(hi_of(r_len2)); op_tag = TAG_SUB1; end
            5'd24: begin op_a = zx(lo_of(r_wa2));  op_b = zx(lo_of(r_len2)); op_tag = TAG_SUB0; end
            default: begin
                op_a   = '0;
                op_b   = '0;
                op_tag = TAG_LEN;
            end
        endcase
    end

    assign pw_full = FULL_W'(r_prod);
    assign pw_dot  = (FULL_W + 1)'(r_prod);
    assign pw_acc  = ACC_W'(r_prod);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ent       = r_ent;
        n_hit       = r_hit;
        n_near_seen = r_near_seen;
        n_len2      = r_len2;
        n_wa2       = r_wa2;
        n_wb2       = r_wb2;
        n_thr2      = r_thr2;
        n_dot       = r_dot;
        n_acc       = r_acc;
        n_prod      = op_a * op_b;
        n_ptag      = op_tag;
        n_pvalid    = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        n_out_near  = r_out_near;
        o_q_pop     = 1'b0;
        near_now    = r_near_seen || r_hit;

        // retire the product issued last cycle
        if (r_pvalid) begin
            case (r_ptag)
                TAG_LEN:  n_len2 = r_len2 + pw_full;
                TAG_WA:   n_wa2  = r_wa2 + pw_full;
                TAG_WB:   n_wb2  = r_wb2 + pw_full;
                TAG_DOT:  n_dot  = r_dot + pw_dot;
                TAG_THR:  n_thr2 = pw_full;
                TAG_ADD0: n_acc  = r_acc + pw_acc;
                TAG_ADD1: n_acc  = r_acc + (pw_acc <<< HALF_W);
                TAG_ADD2: n_acc  = r_acc + (pw_acc <<< (2 * HALF_W));
                TAG_SUB0: n_acc  = r_acc - pw_acc;
                TAG_SUB1: n_acc  = r_acc - (pw_acc <<< HALF_W);
                TAG_SUB2: n_acc  = r_acc - (pw_acc <<< (2 * HALF_W));
                default:  n_acc  = r_acc;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_ent   = i_entry;
                    n_hit   = 1'b0;
                    if (i_entry.test) begin
                        n_len2  = '0;
                        n_wa2   = '0;
                        n_wb2   = '0;
                        n_thr2  = '0;
                        n_dot   = '0;
                        n_acc   = '0;
                        n_step  = '0;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL: begin
                n_pvalid = 1'b1;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_P1_LAST) begin
                    n_state = S_DRN1;
                end else if (r_step == STEP_P2_LAST) begin
                    n_state = S_DRN2;
                end
            end
            S_DRN1: n_state = S_CHK1;
            S_CHK1: begin
                if (r_len2 == '0) begin
                    // zero-length segment: skip entirely
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else if ((r_wa2 < r_thr2) || (r_wb2 < r_thr2)) begin
                    n_hit   = 1'b1;
                    n_state = S_FIN;
                end else if (r_dot[FULL_W] || (dot_u > r_len2)) begin
                    // foot falls off the segment
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_step  = STEP_P2_FIRST;
                    n_state = S_MUL;
                end
            end
            S_DRN2: n_state = S_CHK2;
            S_CHK2: begin
                n_hit   = !r_acc[ACC_W-1] && (r_acc != '0);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ent.last) begin
                    n_near_seen = near_now;
                    n_state     = S_IDLE;
                end else if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_near  = near_now;
                    n_near_seen = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_near_seen <= 1'b0;
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_near_seen <= n_near_seen;
            r_pvalid    <= n_pvalid;
            r_out_valid <= n_out_valid;
        end
        r_step     <= n_step;
        r_ent      <= n_ent;
        r_hit      <= n_hit;
        r_len2     <= n_len2;
        r_wa2      <= n_wa2;
        r_wb2      <= n_wb2;
        r_thr2     <= n_thr2;
        r_dot      <= n_dot;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_ptag     <= n_ptag;
        r_out_near <= n_out_near;
    end

    `PPV_ASSERT(a_dot_nonneg, i_clk, i_rst_n, ((r_state == S_MUL) && (r_step == STEP_P2_FIRST)) |-> !r_dot[FULL_W], "negative projection entered second phase")
    `PPV_ASSERT(a_step_range, i_clk, i_rst_n, (r_state == S_MUL) |-> (r_step <= STEP_P2_LAST), "multiply step out of range")
    `PPV_ASSERT(a_prod_src, i_clk, i_rst_n, r_pvalid |-> ($past(r_state) == S_MUL), "product retired without issue")

endmodule

### rtl/core/polyline_proximity_veto_top.sv
// A batch-end point that forms no segment gives its verdict sooner than one whose
//   segment needs the full test. A point with no segment skips the multiplier; a
//   segment runs a first phase on the one 20x20 multiplier, and a second phase
//   only when the endpoint and projection checks do not decide it.
// A two-entry queue lets points be accepted while the multiplier works.
// Reset: synchronous, active low; clears batch state, queue, output and registers.
module polyline_proximity_veto_top
    import ppv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [COORD_W-1:0] i_point_z,
    input  logic               i_track_start,
    input  logic               i_batch_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_near_track,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [COORD_W-1:0]   r_vertex_x, n_vertex_x;
    logic [COORD_W-1:0]   r_vertex_y, n_vertex_y;
    logic [COORD_W-1:0]   r_vertex_z, n_vertex_z;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    t_seg_entry           q_wdata;
    t_seg_entry           q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_vertex_x = r_vertex_x;
        n_vertex_y = r_vertex_y;
        n_vertex_z = r_vertex_z;
        n_thr      = r_thr;
        if (wr_en) begin
            unique case (reg_idx)
                REG_VX:  n_vertex_x = pwdata[COORD_W-1:0];
                REG_VY:  n_vertex_y = pwdata[COORD_W-1:0];
                REG_VZ:  n_vertex_z = pwdata[COORD_W-1:0];
                REG_THR: n_thr      = pwdata[THR_W-1:0];
                default: n_thr      = r_thr;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VX:  prdata = DATA_W'(r_vertex_x);
            REG_VY:  prdata = DATA_W'(r_vertex_y);
            REG_VZ:  prdata = DATA_W'(r_vertex_z);
            REG_THR: prdata = DATA_W'(r_thr);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_x <= '0;
            r_vertex_y <= '0;
            r_vertex_z <= '0;
            r_thr      <= THR_RESET;
        end else begin
            r_vertex_x <= n_vertex_x;
            r_vertex_y <= n_vertex_y;
            r_vertex_z <= n_vertex_z;
            r_thr      <= n_thr;
        end
    end

    ppv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_track_start (i_track_start),
        .i_batch_end   (i_batch_end),
        .i_vertex_x    (r_vertex_x),
        .i_vertex_y    (r_vertex_y),
        .i_vertex_z    (r_vertex_z),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (q_wdata)
    );

    ppv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    ppv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_entry      (q_rdata),
        .i_thr        (r_thr),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_near_track (o_near_track)
    );

endmodule

### test/tb_polyline_proximity_veto_top.sv
`timescale 1ns / 1ps

module tb_polyline_proximity_veto_top;
    import ppv_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 128;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int PHASE_ITEMS    = 300;
    localparam int NUM_PHASES     = 6;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               start;
        logic               last;
    } t_point;

    typedef struct packed {
        t_point pt;
        bit     typed;
        bit     near_val;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [COORD_W-1:0] i_point_x;
    logic [COORD_W-1:0] i_point_y;
    logic [COORD_W-1:0] i_point_z;
    logic               i_track_start;
    logic               i_batch_end;
    logic               o_valid;
    logic               i_stall;
    logic               o_near_track;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    polyline_proximity_veto_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_track_start (i_track_start),
        .i_batch_end   (i_batch_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_near_track  (o_near_track),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the block: configuration and batch state.
    longint vtx_x, vtx_y, vtx_z;
    longint thr_cfg;
    longint prev_x, prev_y, prev_z;
    bit     prev_ok;
    bit     seen_near;

    bit        near_expected[$];
    t_stim_row dir_rows[$];

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;
    int idle_cycles;
    int errors;
    int points_sent;
    int verdicts_seen;
    int near_seen_cnt;
    int settings_cnt;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit segment_is_near(input longint cx, input longint cy,
                                           input longint cz);
        longint dx, dy, dz, ax, ay, az, bx, by, bz;
        longint len2, wa2, wb2, dot, thr2;
        bit [127:0] lhs, rhs, len_w, wa_w, thr_w, dot_w;
        begin
            dx = cx - prev_x;   dy = cy - prev_y;   dz = cz - prev_z;
            ax = vtx_x - prev_x; ay = vtx_y - prev_y; az = vtx_z - prev_z;
            bx = vtx_x - cx;    by = vtx_y - cy;    bz = vtx_z - cz;
            len2 = dx * dx + dy * dy + dz * dz;
            wa2  = ax * ax + ay * ay + az * az;
            wb2  = bx * bx + by * by + bz * bz;
            dot  = dx * ax + dy * ay + dz * az;
            thr2 = thr_cfg * thr_cfg;
            if (len2 == 0) return 1'b0;
            if (wa2 < thr2 || wb2 < thr2) return 1'b1;
            // foot must fall on the segment, ends included
            if (dot < 0 || dot > len2) return 1'b0;
            len_w = 128'(len2);
            wa_w  = 128'(wa2);
            thr_w = 128'(thr2);
            dot_w = 128'(dot);
            lhs = wa_w * len_w;
            rhs = thr_w * len_w + dot_w * dot_w;
            return lhs < rhs;
        end
    endfunction

    task automatic predict_point(input t_point p, input bit typed, input bit typed_near);
        longint cx, cy, cz;
        begin
            cx = longint'($signed(p.x));
            cy = longint'($signed(p.y));
            cz = longint'($signed(p.z));
            if (!p.start && prev_ok && segment_is_near(cx, cy, cz))
                seen_near = 1'b1;
            prev_x  = cx;
            prev_y  = cy;
            prev_z  = cz;
            prev_ok = 1'b1;
            if (p.last) begin
                near_expected = {near_expected, (typed ? typed_near : seen_near)};
                seen_near = 1'b0;
                prev_ok   = 1'b0;
            end
        end
    endtask

    task automatic send_point(input t_point p, input bit typed, input bit typed_near);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid       <= 1'b1;
            i_point_x     <= p.x;
            i_point_y     <= p.y;
            i_point_z     <= p.z;
            i_track_start <= p.start;
            i_batch_end   <= p.last;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            predict_point(p, typed, typed_near);
            points_sent++;
        end
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= data;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            case (idx)
                REG_VX:  vtx_x   = longint'($signed(data[COORD_W-1:0]));
                REG_VY:  vtx_y   = longint'($signed(data[COORD_W-1:0]));
                REG_VZ:  vtx_z   = longint'($signed(data[COORD_W-1:0]));
                REG_THR: thr_cfg = longint'(data[THR_W-1:0]);
                default: ;
            endcase
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drain all verdicts, then let any point with no verdict finish in the math unit.
    task automatic wait_idle();
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (near_expected.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic load_vertex(input int vx, input int vy, input int vz, input int thr);
        logic [DATA_W-1:0] junk;
        begin
            // set the unused upper bits to check that they are dropped
            junk = $urandom();
            apb_write(REG_VX, {junk[DATA_W-1:COORD_W], COORD_W'(vx)});
            junk = $urandom();
            apb_write(REG_VY, {junk[DATA_W-1:COORD_W], COORD_W'(vy)});
            junk = $urandom();
            apb_write(REG_VZ, {junk[DATA_W-1:COORD_W], COORD_W'(vz)});
            junk = $urandom();
            apb_write(REG_THR, {junk[DATA_W-1:THR_W], THR_W'(thr)});
            settings_cnt++;
        end
    endtask

    task automatic add_row(input int x, input int y, input int z, input bit s, input bit e,
                           input bit typed, input bit nv);
        t_stim_row r;
        begin
            r.pt.x     = COORD_W'(x);
            r.pt.y     = COORD_W'(y);
            r.pt.z     = COORD_W'(z);
            r.pt.start = s;
            r.pt.last  = e;
            r.typed    = typed;
            r.near_val = nv;
            dir_rows = {dir_rows, r};
        end
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input longint center);
        int spread;
        int off;
        begin
            spread = 2 * int'(thr_cfg) + 64;
            off    = int'($urandom_range(2 * spread)) - spread;
            return COORD_W'(center + longint'(off));
        end
    endfunction

    task automatic run_batches(input int n_items, input int max_len);
        t_point p;
        int     len, sel, sent;
        bit     noise;
        begin
            sent = 0;
            p    = '0;
            while (sent < n_items) begin
                len   = $urandom_range(max_len, 1);
                noise = ($urandom_range(99) < 10);
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(99);
                    if (k > 0 && sel < 10) begin
                        // repeat the previous point: zero-length segment
                    end else if (sel < 25) begin
                        p.x = COORD_W'($urandom());
                        p.y = COORD_W'($urandom());
                        p.z = COORD_W'($urandom());
                    end else begin
                        p.x = near_coord(vtx_x);
                        p.y = near_coord(vtx_y);
                        p.z = near_coord(vtx_z);
                    end
                    p.start = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 5);
                    p.last  = (k == len - 1);
                    if (noise) begin
                        p.start = 1'($urandom_range(1));
                        p.last  = 1'($urandom_range(1));
                    end
                    send_point(p, 1'b0, 1'b0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stall plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Verdict checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                verdicts_seen++;
                if (o_near_track) near_seen_cnt++;
                if (near_expected.size() == 0) begin
                    $error("near_track: no verdict pending, actual %0b", o_near_track);
                    errors++;
                end else begin
                    if (o_near_track !== near_expected[0]) begin
                        $error("near_track mismatch: expected %0b, actual %0b",
                               near_expected[0], o_near_track);
                        errors++;
                    end
                    void'(near_expected.pop_front());
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_polyline_proximity_veto_top failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_z     = '0;
        i_track_start = 1'b0;
        i_batch_end   = 1'b0;
        i_stall       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        vtx_x = 0; vtx_y = 0; vtx_z = 0;
        thr_cfg = longint'(THR_RESET);
        prev_x = 0; prev_y = 0; prev_z = 0;
        prev_ok = 1'b0;
        seen_near = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        idle_cycles = 0;
        errors = 0;
        points_sent = 0;
        verdicts_seen = 0;
        near_seen_cnt = 0;
        settings_cnt = 0;

        // Directed points, vertex at origin and threshold at its reset value.
        add_row(0, 0, 0, 1, 1, 1, 0);                    // lone point on the vertex
        add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 1, 1, 0);                    // zero-length segment
        add_row(100, 0, 0, 1, 0, 0, 0);
        add_row(200, 0, 0, 0, 1, 1, 1);                  // endpoint inside
        add_row(-1000, 150, 0, 1, 0, 0, 0);
        add_row(1000, 150, 0, 0, 1, 0, 0);               // perpendicular foot inside
        add_row(-1000, 160, 0, 1, 0, 0, 0);
        add_row(1000, 160, 0, 0, 1, 0, 0);               // distance equals threshold
        add_row(500, 100, 0, 1, 0, 0, 0);
        add_row(1000, 100, 0, 0, 1, 0, 0);               // foot beyond the segment
        add_row(131071, 131071, 131071, 1, 0, 0, 0);
        add_row(-131072, -131072, -131072, 0, 1, 0, 0);
        add_row(-131072, 131071, -131072, 1, 0, 0, 0);
        add_row(131071, -131072, 131071, 0, 1, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0);                    // first after batch end, no start
        add_row(50, 0, 0, 0, 1, 0, 0);
        add_row(5000, 0, 0, 1, 0, 0, 0);
        add_row(6000, 0, 0, 0, 0, 0, 0);
        add_row(0, 100, 0, 1, 0, 0, 0);                  // new track inside the batch
        add_row(0, 200, 0, 0, 1, 0, 0);
        add_row(-131072, 0, 131071, 1, 0, 0, 0);
        add_row(131071, 0, -131072, 0, 1, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_point(dir_rows[r].pt, dir_rows[r].typed, dir_rows[r].near_val);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_vertex(0, 0, 0, 160);
                1: load_vertex(131071, -131072, 131071, 65535);
                2: load_vertex($urandom(), $urandom(), $urandom(), 0);
                3: load_vertex(-131072, 131071, -131072, $urandom_range(400));
                default: load_vertex($urandom(), $urandom(), $urandom(),
                                     $urandom_range(4000));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            @(posedge i_clk);
            if (ph == 2) begin
                // stall the output long enough for the point queue to back up
                hold_req = 1'b1;
                run_batches(PHASE_ITEMS, 3);
            end else begin
                run_batches(PHASE_ITEMS, 8);
            end
        end

        wait_idle();
        $display("Sent %0d points over %0d register settings; checked %0d verdicts, %0d near.",
                 points_sent, settings_cnt, verdicts_seen, near_seen_cnt);
        if (errors == 0) begin
            $display("tb_polyline_proximity_veto_top passed");
        end else begin
            $display("tb_polyline_proximity_veto_top failed");
        end
        $finish;
    end

endmodule
